>>> rtl/core/sbdc_pkg.sv
// Shared types and codes for the sector buffer disk controller.
package sbdc_pkg;

	typedef enum logic [2:0] {
		OP_SET_MODE   = 3'd0,
		OP_SET_SECTOR = 3'd1,
		OP_XFER       = 3'd2,
		OP_DATA       = 3'd3,
		OP_COUNT      = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK     = 2'd0,
		ERR_MODE   = 2'd1,
		ERR_INDEX  = 2'd2,
		ERR_SECTOR = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDATA,
		ST_XFER_RD,
		ST_XFER_WR,
		ST_XFER_END
	} state_t;

	localparam logic [15:0] MODE_READ  = 16'd0;
	localparam logic [15:0] MODE_WRITE = 16'd1;

	localparam logic [6:0] SECTOR_COUNT_RESET = 7'd64;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] value;
	} cmd_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [1:0]  error;
	} result_t;

endpackage

>>> rtl/core/sector_buffer_disk_controller.sv
// Register commands answer through the registered done strobe; a buffer byte read passes
// the buffer RAM read register and then the done register; a sector transfer runs the copy
// loop over the sector and then the end state. One register command per cycle while busy
// is low; a transfer holds busy through both, moving one byte per cycle through the RAM ports.
// Reset clears mode, position, index and buffer fill count (the buffer reads as zero);
// disk contents are undefined until written. Results are strobed and cannot be stalled.
module sector_buffer_disk_controller #(
	parameter int SECTOR_BYTES = 512,
	parameter int DISK_SECTORS = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  sbdc_pkg::cmd_t          cmd,
	output logic                    busy,
	output logic                    done,
	output sbdc_pkg::result_t       result,
	input  logic                    cfg_we,
	input  logic [6:0]              cfg_data
);

	localparam int BA_W = $clog2(SECTOR_BYTES);
	localparam int DA_W = $clog2(DISK_SECTORS * SECTOR_BYTES);

	logic            buf_we;
	logic [BA_W-1:0] buf_waddr;
	logic [7:0]      buf_wdata;
	logic            buf_re;
	logic [BA_W-1:0] buf_raddr;
	logic [7:0]      buf_rdata;
	logic            dsk_we;
	logic [DA_W-1:0] dsk_waddr;
	logic [7:0]      dsk_wdata;
	logic            dsk_re;
	logic [DA_W-1:0] dsk_raddr;
	logic [7:0]      dsk_rdata;

	sbdc_ctrl #(
		.SECTOR_BYTES(SECTOR_BYTES),
		.DISK_SECTORS(DISK_SECTORS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.buf_we    (buf_we),
		.buf_waddr (buf_waddr),
		.buf_wdata (buf_wdata),
		.buf_re    (buf_re),
		.buf_raddr (buf_raddr),
		.buf_rdata (buf_rdata),
		.dsk_we    (dsk_we),
		.dsk_waddr (dsk_waddr),
		.dsk_wdata (dsk_wdata),
		.dsk_re    (dsk_re),
		.dsk_raddr (dsk_raddr),
		.dsk_rdata (dsk_rdata)
	);

	sbdc_ram #(
		.DEPTH(SECTOR_BYTES),
		.WIDTH(8)
	) u_sector_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	sbdc_ram #(
		.DEPTH(DISK_SECTORS * SECTOR_BYTES),
		.WIDTH(8)
	) u_disk (
		.clk   (clk),
		.we    (dsk_we),
		.waddr (dsk_waddr),
		.wdata (dsk_wdata),
		.re    (dsk_re),
		.raddr (dsk_raddr),
		.rdata (dsk_rdata)
	);

endmodule

>>> rtl/core/sbdc_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module sbdc_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/sbdc_ctrl.sv
// Command sequencer: mode, position, index, fill count and sector copy loop.
module sbdc_ctrl #(
	parameter int SECTOR_BYTES = 512,
	parameter int DISK_SECTORS = 64,
	localparam int BA_W = $clog2(SECTOR_BYTES),
	localparam int DA_W = $clog2(DISK_SECTORS * SECTOR_BYTES)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  sbdc_pkg::cmd_t          cmd,
	output logic                    busy,
	output logic                    done,
	output sbdc_pkg::result_t       result,
	input  logic                    cfg_we,
	input  logic [6:0]              cfg_data,
	output logic                    buf_we,
	output logic [BA_W-1:0]         buf_waddr,
	output logic [7:0]              buf_wdata,
	output logic                    buf_re,
	output logic [BA_W-1:0]         buf_raddr,
	input  logic [7:0]              buf_rdata,
	output logic                    dsk_we,
	output logic [DA_W-1:0]         dsk_waddr,
	output logic [7:0]              dsk_wdata,
	output logic                    dsk_re,
	output logic [DA_W-1:0]         dsk_raddr,
	input  logic [7:0]              dsk_rdata
);

	localparam int IW = BA_W + 1;
	localparam logic [16:0] DS_LIM = 17'(DISK_SECTORS);
	localparam logic [IW-1:0] SB_FULL = IW'(SECTOR_BYTES);
	localparam logic [IW-1:0] SB_LAST = IW'(SECTOR_BYTES - 1);

	sbdc_pkg::state_t  state_q, state_d;
	logic              mode_q;
	logic [15:0]       pos_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     fill_q;   // entries at or past this read as zero
	logic [6:0]        cnt_q;
	logic [IW-1:0]     ptr_q;
	logic [DA_W-1:0]   dptr_q;
	logic              valid_s1;
	logic [BA_W-1:0]   baddr_s1;
	logic [DA_W-1:0]   daddr_s1;
	logic              ok_s1;
	logic              rd_ok_q;
	logic              done_q, done_d;
	sbdc_pkg::result_t res_q, res_d;

	logic              accept;
	logic              in_xfer;
	logic              idx_end;
	logic              sec_end;
	logic              ptr_last;
	logic [16:0]       cnt_ext;
	logic [16:0]       eff_w;

	assign accept   = start && (state_q == sbdc_pkg::ST_IDLE);
	assign in_xfer  = (state_q == sbdc_pkg::ST_XFER_RD) || (state_q == sbdc_pkg::ST_XFER_WR);
	assign idx_end  = idx_q >= SB_FULL;
	assign ptr_last = ptr_q == SB_LAST;
	assign cnt_ext  = {10'd0, cnt_q};
	assign eff_w    = (cnt_ext < DS_LIM) ? cnt_ext : DS_LIM;
	assign sec_end  = {1'b0, pos_q} >= eff_w;

	assign busy   = state_q != sbdc_pkg::ST_IDLE;
	assign done   = done_q;
	assign result = res_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			sbdc_pkg::ST_IDLE: begin
				if (start) begin
					case (cmd.operation)
						sbdc_pkg::OP_DATA: begin
							if (!idx_end && !mode_q) state_d = sbdc_pkg::ST_RDATA;
						end
						sbdc_pkg::OP_XFER: begin
							if (!sec_end) begin
								state_d = mode_q ? sbdc_pkg::ST_XFER_WR : sbdc_pkg::ST_XFER_RD;
							end
						end
						default: state_d = sbdc_pkg::ST_IDLE;
					endcase
				end
			end
			sbdc_pkg::ST_RDATA:  state_d = sbdc_pkg::ST_IDLE;
			sbdc_pkg::ST_XFER_RD,
			sbdc_pkg::ST_XFER_WR: begin
				if (ptr_last) state_d = sbdc_pkg::ST_XFER_END;
			end
			sbdc_pkg::ST_XFER_END: state_d = sbdc_pkg::ST_IDLE;
			default: state_d = sbdc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		done_d    = 1'b0;
		res_d     = '0;
		buf_we    = 1'b0;
		buf_waddr = idx_q[BA_W-1:0];
		buf_wdata = cmd.value[7:0];
		buf_re    = 1'b0;
		buf_raddr = idx_q[BA_W-1:0];
		dsk_we    = 1'b0;
		dsk_waddr = daddr_s1;
		dsk_wdata = ok_s1 ? buf_rdata : 8'd0;
		dsk_re    = 1'b0;
		dsk_raddr = dptr_q;
		case (state_q)
			sbdc_pkg::ST_IDLE: begin
				if (start) begin
					case (cmd.operation)
						sbdc_pkg::OP_SET_MODE: begin
							done_d = 1'b1;
							if (cmd.value != sbdc_pkg::MODE_READ &&
							    cmd.value != sbdc_pkg::MODE_WRITE) begin
								res_d.error = sbdc_pkg::ERR_MODE;
							end
						end
						sbdc_pkg::OP_XFER: begin
							if (sec_end) begin
								done_d      = 1'b1;
								res_d.error = sbdc_pkg::ERR_SECTOR;
							end
						end
						sbdc_pkg::OP_DATA: begin
							if (idx_end) begin
								done_d      = 1'b1;
								res_d.error = sbdc_pkg::ERR_INDEX;
							end else if (mode_q) begin
								done_d = 1'b1;
								buf_we = 1'b1;
							end else begin
								buf_re = 1'b1;
							end
						end
						sbdc_pkg::OP_COUNT: begin
							done_d          = 1'b1;
							res_d.read_data = eff_w[15:0];
						end
						default: done_d = 1'b1;
					endcase
				end
			end
			sbdc_pkg::ST_RDATA: begin
				done_d          = 1'b1;
				res_d.read_data = rd_ok_q ? {8'd0, buf_rdata} : 16'd0;
			end
			sbdc_pkg::ST_XFER_RD: dsk_re = 1'b1;
			sbdc_pkg::ST_XFER_WR: begin
				buf_re    = 1'b1;
				buf_raddr = ptr_q[BA_W-1:0];
			end
			sbdc_pkg::ST_XFER_END: done_d = 1'b1;
			default: done_d = 1'b0;
		endcase
		// write-back half of the copy loop, in the cycle after the read
		if (valid_s1) begin
			if (mode_q) begin
				dsk_we = 1'b1;
			end else begin
				buf_we    = 1'b1;
				buf_waddr = baddr_s1;
				buf_wdata = dsk_rdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sbdc_pkg::ST_IDLE;
			done_q   <= 1'b0;
			mode_q   <= 1'b0;
			pos_q    <= '0;
			idx_q    <= '0;
			fill_q   <= '0;
			cnt_q    <= sbdc_pkg::SECTOR_COUNT_RESET;
			ptr_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			done_q   <= done_d;
			valid_s1 <= in_xfer;
			if (cfg_we) cnt_q <= cfg_data;
			if (in_xfer) ptr_q <= ptr_q + IW'(1);
			if (accept) begin
				case (cmd.operation)
					sbdc_pkg::OP_SET_MODE: begin
						idx_q  <= '0;
						fill_q <= '0;
						if (cmd.value == sbdc_pkg::MODE_READ ||
						    cmd.value == sbdc_pkg::MODE_WRITE) begin
							mode_q <= cmd.value[0];
						end
					end
					sbdc_pkg::OP_SET_SECTOR: begin
						idx_q  <= '0;
						fill_q <= '0;
						pos_q  <= cmd.value;
					end
					sbdc_pkg::OP_XFER: begin
						if (!sec_end) ptr_q <= '0;
					end
					sbdc_pkg::OP_DATA: begin
						if (!idx_end) begin
							idx_q <= idx_q + IW'(1);
							if (mode_q && idx_q >= fill_q) fill_q <= idx_q + IW'(1);
						end
					end
					default: idx_q <= idx_q;
				endcase
			end
			if (state_q == sbdc_pkg::ST_XFER_END) begin
				pos_q <= pos_q + 16'd1;
				if (!mode_q) fill_q <= SB_FULL;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q    <= res_d;
		rd_ok_q  <= idx_q < fill_q;
		baddr_s1 <= ptr_q[BA_W-1:0];
		daddr_s1 <= dptr_q;
		ok_s1    <= ptr_q < fill_q;
		if (accept && cmd.operation == sbdc_pkg::OP_XFER) begin
			dptr_q <= DA_W'(32'(pos_q) * 32'(SECTOR_BYTES));
		end else if (in_xfer) begin
			dptr_q <= dptr_q + DA_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= SB_FULL && fill_q <= SB_FULL)
		else $error("buffer index or fill count past sector end");

	a_s1_in_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == sbdc_pkg::ST_XFER_RD || state_q == sbdc_pkg::ST_XFER_WR ||
		              state_q == sbdc_pkg::ST_XFER_END))
		else $error("copy write-back outside a transfer");

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sbdc_pkg::ST_XFER_END |=> done_q)
		else $error("transfer finished without a result");

	a_loop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !ptr_last) |=> (in_xfer && !done_q))
		else $error("copy loop left early");
`endif

endmodule
